// ===== sv/brb_pkg.sv =====
// Package for the byte ring buffer: field widths, action and status codes,
// controller states and the command and status bundles between the modules.
// Depends on nothing; brb_ctrl, brb_dp and the top module import it.
`default_nettype none

package brb_pkg;

  // Fixed field widths of the item and result channels.
  localparam int ACT_W  = 3;
  localparam int LEN_W  = 12;
  localparam int DATA_W = 8;
  localparam int ROOM_W = 7;
  localparam int CFG_W  = 13;
  localparam int STAT_W = 2;
  localparam int CNT_W  = 7;

  // Action codes carried by an input item.
  localparam logic [ACT_W-1:0] ACT_WRITE    = 3'd0;
  localparam logic [ACT_W-1:0] ACT_READ     = 3'd1;
  localparam logic [ACT_W-1:0] ACT_DISCARD  = 3'd2;
  localparam logic [ACT_W-1:0] ACT_BACKUP   = 3'd3;
  localparam logic [ACT_W-1:0] ACT_ROLLBACK = 3'd4;

  // Status codes carried by a result.
  localparam logic [STAT_W-1:0] ST_OK    = 2'd0;
  localparam logic [STAT_W-1:0] ST_AGAIN = 2'd1;
  localparam logic [STAT_W-1:0] ST_STRAY = 2'd2;

  // Controller states.
  typedef enum logic [2:0] {
    S_IDLE,
    S_DECODE,
    S_DISC,
    S_RD_MOD,
    S_RD_WAIT,
    S_RD_FETCH,
    S_RD_LOAD,
    S_RESP
  } brb_state_e;

  // Commands from the controller to the datapath, valid for one cycle.
  typedef struct packed {
    logic              latch;
    logic              status_we;
    logic [STAT_W-1:0] status_val;
    logic              refuse_set;
    logic              refuse_clr;
    logic              pend_load;
    logic              pend_dec;
    logic              store;
    logic              backup;
    logic              rollback;
    logic              mod_start;
    logic              mod_sel_read;
    logic              disc_finish;
    logic              rd_setup;
    logic              rd_end;
    logic              rd_fetch;
    logic              load_resp;
    logic              load_byte;
  } brb_cmd_t;

  // Status from the datapath to the controller.
  typedef struct packed {
    logic [ACT_W-1:0] action;
    logic             first;
    logic             fits;
    logic             len_zero;
    logic             pend_zero;
    logic             refusing;
    logic             is_empty;
    logic             n_zero;
    logic             mod_busy;
    logic             last_byte;
    logic             out_free;
  } brb_sts_t;

endpackage

`default_nettype wire

// ===== sv/brb_ram.sv =====
// Generic single-port-write, single-port-read RAM with a registered read.
// Depends on nothing.
`default_nettype none

module brb_ram #(
  parameter int WIDTH = 8,
  parameter int DEPTH = 4096
) (
  input  wire logic                     clk_i,
  input  wire logic                     we_i,
  input  wire logic [$clog2(DEPTH)-1:0] waddr_i,
  input  wire logic [WIDTH-1:0]         wdata_i,
  input  wire logic                     re_i,
  input  wire logic [$clog2(DEPTH)-1:0] raddr_i,
  output logic      [WIDTH-1:0]         rdata_o
);

  logic [WIDTH-1:0] mem_q [DEPTH];
  logic [WIDTH-1:0] rdata_q;

  // Write port and registered read port.
  always_ff @(posedge clk_i) begin
    if (we_i) begin
      mem_q[waddr_i] <= wdata_i;
    end
    if (re_i) begin
      rdata_q <= mem_q[raddr_i];
    end
  end

  assign rdata_o = rdata_q;

endmodule

`default_nettype wire

// ===== sv/brb_mod.sv =====
// Bit-serial restoring remainder unit: dividend modulo divisor, one
// dividend bit per cycle. Depends on nothing.
`default_nettype none

module brb_mod #(
  parameter int DW = 13,
  parameter int SW = 13
) (
  input  wire logic          clk_i,
  input  wire logic          rst_ni,
  input  wire logic          start_i,
  input  wire logic [DW-1:0] dividend_i,
  input  wire logic [SW-1:0] divisor_i,
  output logic               busy_o,
  output logic      [SW-1:0] rem_o
);

  localparam int CNTW = $clog2(DW + 1);

  logic [CNTW-1:0] cnt_q, cnt_d;
  logic [SW-1:0]   rem_q, rem_d;
  logic [DW-1:0]   sh_q, sh_d;
  logic [SW:0]     trial;
  logic [SW:0]     diff;

  // Shift in the next dividend bit and subtract the divisor if it fits.
  always_comb begin
    trial = {rem_q, sh_q[DW-1]};
    diff  = trial - {1'b0, divisor_i};
    cnt_d = cnt_q;
    rem_d = rem_q;
    sh_d  = sh_q;
    if (start_i) begin
      cnt_d = CNTW'(DW);
      rem_d = '0;
      sh_d  = dividend_i;
    end else if (cnt_q != '0) begin
      cnt_d = cnt_q - CNTW'(1);
      rem_d = (trial >= {1'b0, divisor_i}) ? diff[SW-1:0] : trial[SW-1:0];
      sh_d  = {sh_q[DW-2:0], 1'b0};
    end
  end

  // Step counter.
  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      cnt_q <= '0;
    end else begin
      cnt_q <= cnt_d;
    end
  end

  // Partial remainder and dividend shift register.
  always_ff @(posedge clk_i) begin
    rem_q <= rem_d;
    sh_q  <= sh_d;
  end

  assign busy_o = (cnt_q != '0);
  assign rem_o  = rem_q;

endmodule

`default_nettype wire

// ===== sv/brb_ctrl.sv =====
// Controller state machine of the byte ring buffer: sequences one item at
// a time and drives the datapath. Depends on brb_pkg.
`default_nettype none

module brb_ctrl
  import brb_pkg::*;
(
  input  wire logic     clk_i,
  input  wire logic     rst_ni,
  input  wire logic     in_valid_i,
  input  wire logic     cfg_we_i,
  input  wire brb_sts_t sts_i,
  output logic          in_ready_o,
  output brb_cmd_t      cmd_o
);

  brb_state_e state_q, state_d;
  logic       accept;

  // An item is taken only while idle and not during a register write.
  assign in_ready_o = (state_q == S_IDLE) && !cfg_we_i;
  assign accept     = in_valid_i && in_ready_o;

  // Next-state logic.
  always_comb begin
    state_d = state_q;
    case (state_q)
      S_IDLE: begin
        if (accept) state_d = S_DECODE;
      end
      S_DECODE: begin
        case (sts_i.action)
          ACT_DISCARD: state_d = S_DISC;
          ACT_READ: begin
            if (!sts_i.is_empty && !sts_i.n_zero) state_d = S_RD_MOD;
            else                                  state_d = S_RESP;
          end
          default: state_d = S_RESP;
        endcase
      end
      S_DISC: begin
        if (!sts_i.mod_busy) state_d = S_RESP;
      end
      S_RD_MOD: state_d = S_RD_WAIT;
      S_RD_WAIT: begin
        if (!sts_i.mod_busy) state_d = S_RD_FETCH;
      end
      S_RD_FETCH: state_d = S_RD_LOAD;
      S_RD_LOAD: begin
        if (sts_i.out_free) state_d = sts_i.last_byte ? S_IDLE : S_RD_FETCH;
      end
      S_RESP: begin
        if (sts_i.out_free) state_d = S_IDLE;
      end
      default: state_d = S_IDLE;
    endcase
  end

  // Command outputs.
  always_comb begin
    cmd_o = '0;
    case (state_q)
      S_IDLE: begin
        cmd_o.latch = accept;
      end
      S_DECODE: begin
        cmd_o.status_we  = 1'b1;
        cmd_o.status_val = ST_OK;
        case (sts_i.action)
          ACT_WRITE: begin
            if (sts_i.first) begin
              cmd_o.pend_load = 1'b1;
              if (!sts_i.fits) begin
                cmd_o.refuse_set = 1'b1;
                cmd_o.status_val = ST_AGAIN;
              end else begin
                cmd_o.refuse_clr = 1'b1;
                cmd_o.store      = !sts_i.len_zero;
              end
            end else if (sts_i.pend_zero) begin
              cmd_o.status_val = ST_STRAY;
            end else begin
              cmd_o.pend_dec = 1'b1;
              if (sts_i.refusing) cmd_o.status_val = ST_AGAIN;
              else                cmd_o.store      = 1'b1;
            end
          end
          ACT_READ: begin
            if (sts_i.is_empty)     cmd_o.status_val = ST_AGAIN;
            else if (!sts_i.n_zero) cmd_o.rd_setup   = 1'b1;
          end
          ACT_DISCARD:  cmd_o.mod_start = 1'b1;
          ACT_BACKUP:   cmd_o.backup    = 1'b1;
          ACT_ROLLBACK: cmd_o.rollback  = 1'b1;
          default: ;
        endcase
      end
      S_DISC: begin
        cmd_o.disc_finish = !sts_i.mod_busy;
      end
      S_RD_MOD: begin
        cmd_o.mod_start    = 1'b1;
        cmd_o.mod_sel_read = 1'b1;
      end
      S_RD_WAIT: begin
        cmd_o.rd_end = !sts_i.mod_busy;
      end
      S_RD_FETCH: begin
        cmd_o.rd_fetch = 1'b1;
      end
      S_RD_LOAD: begin
        cmd_o.load_byte = sts_i.out_free;
      end
      S_RESP: begin
        cmd_o.load_resp = sts_i.out_free;
      end
      default: ;
    endcase
  end

  // State register.
  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      state_q <= S_IDLE;
    end else begin
      state_q <= state_d;
    end
  end

endmodule

`default_nettype wire

// ===== sv/brb_dp.sv =====
// Datapath of the byte ring buffer: pointers, message bookkeeping, the byte
// store, the remainder unit and the result register.
// Depends on brb_pkg, brb_ram and brb_mod.
`default_nettype none

module brb_dp
  import brb_pkg::*;
#(
  parameter int DEPTH    = 4096,
  parameter int MAX_READ = 64
) (
  input  wire logic              clk_i,
  input  wire logic              rst_ni,
  input  wire logic              cfg_we_i,
  input  wire logic [CFG_W-1:0]  cfg_ring_size_i,
  input  wire logic [ACT_W-1:0]  action_i,
  input  wire logic              first_i,
  input  wire logic [LEN_W-1:0]  length_i,
  input  wire logic [DATA_W-1:0] data_i,
  input  wire logic [ROOM_W-1:0] dest_room_i,
  input  wire logic              out_ready_i,
  input  wire brb_cmd_t          cmd_i,
  output brb_sts_t               sts_o,
  output logic                   out_valid_o,
  output logic [STAT_W-1:0]      status_o,
  output logic [DATA_W-1:0]      data_out_o,
  output logic                   has_data_o,
  output logic                   last_o,
  output logic [CNT_W-1:0]       copied_o,
  output logic                   empty_res_o
);

  localparam int AW = $clog2(DEPTH);
  localparam int SW = $clog2(DEPTH + 1);
  localparam int CW = (SW > CFG_W) ? SW : CFG_W;
  localparam int LW = ((AW > LEN_W) ? AW : LEN_W) + 1;

  // Configuration and pointer state.
  logic [SW-1:0]     size_q, size_d;
  logic [AW-1:0]     wp_q, rp_q, swp_q, srp_q;
  logic [LEN_W-1:0]  pend_q;
  logic              refusing_q;
  logic [AW-1:0]     used_q;

  // Latched item.
  logic [ACT_W-1:0]  act_q;
  logic              first_q;
  logic [LEN_W-1:0]  len_q;
  logic [DATA_W-1:0] data_q;
  logic [ROOM_W-1:0] room_q;

  // Per-item work registers.
  logic [STAT_W-1:0] status_q;
  logic [CNT_W-1:0]  n_q, copied_q;
  logic              empty_end_q;

  // Result register.
  logic              out_valid_q;
  logic [STAT_W-1:0] out_status_q;
  logic [DATA_W-1:0] out_data_q;
  logic              out_has_q, out_last_q, out_empty_q;
  logic [CNT_W-1:0]  out_copied_q;

  logic [CW-1:0]     cfg_ext;
  logic [LW-1:0]     used_full;
  logic [AW-1:0]     wp_inc, rp_inc;
  logic [ROOM_W-1:0] room_sat;
  logic [CNT_W-1:0]  n_comb;
  logic [LW-1:0]     mod_dividend;
  logic              mod_busy;
  logic [SW-1:0]     mod_rem;
  logic [DATA_W-1:0] ram_rdata;
  logic              out_free;

  // Saturate a written ring size into [2, DEPTH].
  always_comb begin
    cfg_ext = CW'(cfg_ring_size_i);
    if (cfg_ext < CW'(2))          size_d = SW'(2);
    else if (cfg_ext > CW'(DEPTH)) size_d = SW'(DEPTH);
    else                           size_d = cfg_ext[SW-1:0];
  end

  // Pointer advance by one with wrap at the ring size.
  assign wp_inc = (LW'(wp_q) + LW'(1) == LW'(size_q)) ? '0 : wp_q + AW'(1);
  assign rp_inc = (LW'(rp_q) + LW'(1) == LW'(size_q)) ? '0 : rp_q + AW'(1);

  // Occupied bytes, tracked every cycle from the current pointers.
  assign used_full = (wp_q >= rp_q) ? (LW'(wp_q) - LW'(rp_q))
                                    : (LW'(wp_q) + LW'(size_q) - LW'(rp_q));

  // Read length: request clipped to the reader's room and the burst limit.
  assign room_sat = (room_q > ROOM_W'(MAX_READ)) ? ROOM_W'(MAX_READ) : room_q;
  assign n_comb   = (LEN_W'(room_sat) < len_q) ? CNT_W'(room_sat)
                                               : len_q[CNT_W-1:0];

  // Remainder unit serves both the discard advance and the read end pointer.
  assign mod_dividend = LW'(rp_q) + (cmd_i.mod_sel_read ? LW'(n_q) : LW'(len_q));

  brb_mod #(
    .DW (LW),
    .SW (SW)
  ) u_mod (
    .clk_i      (clk_i),
    .rst_ni     (rst_ni),
    .start_i    (cmd_i.mod_start),
    .dividend_i (mod_dividend),
    .divisor_i  (size_q),
    .busy_o     (mod_busy),
    .rem_o      (mod_rem)
  );

  // Byte store.
  brb_ram #(
    .WIDTH (DATA_W),
    .DEPTH (DEPTH)
  ) u_ram (
    .clk_i   (clk_i),
    .we_i    (cmd_i.store),
    .waddr_i (wp_q),
    .wdata_i (data_q),
    .re_i    (cmd_i.rd_fetch),
    .raddr_i (rp_q),
    .rdata_o (ram_rdata)
  );

  // Ring size, pointers and message state.
  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      size_q     <= SW'(DEPTH);
      wp_q       <= '0;
      rp_q       <= '0;
      swp_q      <= '0;
      srp_q      <= '0;
      pend_q     <= '0;
      refusing_q <= 1'b0;
    end else if (cfg_we_i) begin
      size_q     <= size_d;
      wp_q       <= '0;
      rp_q       <= '0;
      swp_q      <= '0;
      srp_q      <= '0;
      pend_q     <= '0;
      refusing_q <= 1'b0;
    end else begin
      if (cmd_i.store)       wp_q <= wp_inc;
      if (cmd_i.rd_fetch)    rp_q <= rp_inc;
      if (cmd_i.disc_finish) rp_q <= mod_rem[AW-1:0];
      if (cmd_i.backup) begin
        swp_q <= wp_q;
        srp_q <= rp_q;
      end
      if (cmd_i.rollback) begin
        wp_q <= swp_q;
        rp_q <= srp_q;
      end
      if (cmd_i.pend_load) pend_q <= (len_q == '0) ? '0 : len_q - LEN_W'(1);
      if (cmd_i.pend_dec)  pend_q <= pend_q - LEN_W'(1);
      if (cmd_i.refuse_set) refusing_q <= 1'b1;
      if (cmd_i.refuse_clr) refusing_q <= 1'b0;
    end
  end

  // Item latch and per-item work registers.
  always_ff @(posedge clk_i) begin
    used_q <= used_full[AW-1:0];
    if (cmd_i.latch) begin
      act_q   <= action_i;
      first_q <= first_i;
      len_q   <= length_i;
      data_q  <= data_i;
      room_q  <= dest_room_i;
    end
    if (cmd_i.status_we) status_q <= cmd_i.status_val;
    if (cmd_i.rd_setup) begin
      n_q      <= n_comb;
      copied_q <= '0;
    end
    if (cmd_i.rd_fetch) copied_q <= copied_q + CNT_W'(1);
    if (cmd_i.rd_end)   empty_end_q <= (mod_rem[AW-1:0] == wp_q);
  end

  // Result register: free when empty or being taken this cycle.
  assign out_free = !out_valid_q || out_ready_i;

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      out_valid_q <= 1'b0;
    end else if (cmd_i.load_resp || cmd_i.load_byte) begin
      out_valid_q <= 1'b1;
    end else if (out_ready_i) begin
      out_valid_q <= 1'b0;
    end
  end

  always_ff @(posedge clk_i) begin
    if (cmd_i.load_resp) begin
      out_status_q <= status_q;
      out_data_q   <= '0;
      out_has_q    <= 1'b0;
      out_last_q   <= 1'b1;
      out_copied_q <= '0;
      out_empty_q  <= (rp_q == wp_q);
    end else if (cmd_i.load_byte) begin
      out_status_q <= ST_OK;
      out_data_q   <= ram_rdata;
      out_has_q    <= 1'b1;
      out_last_q   <= (copied_q == n_q);
      out_copied_q <= copied_q;
      out_empty_q  <= empty_end_q;
    end
  end

  // Status toward the controller.
  always_comb begin
    sts_o           = '0;
    sts_o.action    = act_q;
    sts_o.first     = first_q;
    sts_o.fits      = (LW'(len_q) + LW'(used_q)) < LW'(size_q);
    sts_o.len_zero  = (len_q == '0);
    sts_o.pend_zero = (pend_q == '0);
    sts_o.refusing  = refusing_q;
    sts_o.is_empty  = (rp_q == wp_q);
    sts_o.n_zero    = (len_q == '0) || (room_sat == '0);
    sts_o.mod_busy  = mod_busy;
    sts_o.last_byte = (copied_q == n_q);
    sts_o.out_free  = out_free;
  end

  assign out_valid_o = out_valid_q;
  assign status_o    = out_status_q;
  assign data_out_o  = out_data_q;
  assign has_data_o  = out_has_q;
  assign last_o      = out_last_q;
  assign copied_o    = out_copied_q;
  assign empty_res_o = out_empty_q;

endmodule

`default_nettype wire

// ===== sv/byte_ring_buffer_with_rollback.sv =====
// Byte ring buffer with a reserved slot, all-or-nothing message writes and
// pointer backup and rollback.
//
// Items arrive on a valid/ready channel; results leave on another. Each item
// is one action: write a byte, read up to MAX_READ bytes, discard, back up or
// roll back the pointers. A read gives one result per byte, or one without
// data if it reads nothing; every other item gives exactly one result. The
// last flag marks the final result of an item. The ring size is written
// through cfg_we_i/cfg_ring_size_i; the user must write it only while the
// block is idle; the block does not enforce this. It is clamped to [2, DEPTH]
// and clears all pointers. Items are handled one at a time. A write, backup,
// rollback or an empty or zero-length read passes through a decode and a
// response state before the next item can be taken. A discard and a read
// also wait on the bit-serial remainder unit, which computes the wrapped
// pointer in L = max(12, log2 DEPTH)+1 steps. A read then fetches and loads
// its bytes in turn, paced by the registered read port of the byte store.
// When the receiver stalls, the result register holds and the block waits.
// Reset sets the ring size to DEPTH and clears pointers and message state;
// the byte store itself is not cleared and needs no clearing pass.
`default_nettype none

module byte_ring_buffer_with_rollback
  import brb_pkg::*;
#(
  parameter int DEPTH    = 4096,
  parameter int MAX_READ = 64
) (
  input  wire logic              clk_i,
  input  wire logic              rst_ni,
  input  wire logic              cfg_we_i,
  input  wire logic [CFG_W-1:0]  cfg_ring_size_i,
  input  wire logic              in_valid_i,
  output logic                   in_ready_o,
  input  wire logic [ACT_W-1:0]  action_i,
  input  wire logic              first_i,
  input  wire logic [LEN_W-1:0]  length_i,
  input  wire logic [DATA_W-1:0] data_i,
  input  wire logic [ROOM_W-1:0] dest_room_i,
  output logic                   out_valid_o,
  input  wire logic              out_ready_i,
  output logic [STAT_W-1:0]      status_o,
  output logic [DATA_W-1:0]      data_out_o,
  output logic                   has_data_o,
  output logic                   last_o,
  output logic [CNT_W-1:0]       copied_o,
  output logic                   empty_res_o
);

  brb_cmd_t cmd;
  brb_sts_t sts;

  // Controller.
  brb_ctrl u_ctrl (
    .clk_i      (clk_i),
    .rst_ni     (rst_ni),
    .in_valid_i (in_valid_i),
    .cfg_we_i   (cfg_we_i),
    .sts_i      (sts),
    .in_ready_o (in_ready_o),
    .cmd_o      (cmd)
  );

  // Datapath.
  brb_dp #(
    .DEPTH    (DEPTH),
    .MAX_READ (MAX_READ)
  ) u_dp (
    .clk_i           (clk_i),
    .rst_ni          (rst_ni),
    .cfg_we_i        (cfg_we_i),
    .cfg_ring_size_i (cfg_ring_size_i),
    .action_i        (action_i),
    .first_i         (first_i),
    .length_i        (length_i),
    .data_i          (data_i),
    .dest_room_i     (dest_room_i),
    .out_ready_i     (out_ready_i),
    .cmd_i           (cmd),
    .sts_o           (sts),
    .out_valid_o     (out_valid_o),
    .status_o        (status_o),
    .data_out_o      (data_out_o),
    .has_data_o      (has_data_o),
    .last_o          (last_o),
    .copied_o        (copied_o),
    .empty_res_o     (empty_res_o)
  );

  // Only one item is in work at a time.
  a_one_item: assert property (@(posedge clk_i) disable iff (!rst_ni)
    in_valid_i && in_ready_o |=> !in_ready_o)
    else $error("item accepted while another is in work");

  // A result without data is the single, final result of its item.
  a_nodata_last: assert property (@(posedge clk_i) disable iff (!rst_ni)
    out_valid_o && !has_data_o |-> last_o && (copied_o == '0))
    else $error("result without data is not a lone final result");

  // A data byte carries a count between one and the burst limit.
  a_copied_range: assert property (@(posedge clk_i) disable iff (!rst_ni)
    out_valid_o && has_data_o |-> (copied_o != '0) && (copied_o <= CNT_W'(MAX_READ)))
    else $error("byte count out of range");

  // The result register is never overwritten while it holds a pending result.
  a_no_overwrite: assert property (@(posedge clk_i) disable iff (!rst_ni)
    out_valid_o && !out_ready_i |-> !cmd.load_resp && !cmd.load_byte)
    else $error("pending result overwritten");

endmodule

`default_nettype wire
